// File: hw/rtl/assoc_list_key_value_table_assert.svh
// assertion macros shared by the table rtl
`ifndef ASSOC_LIST_KEY_VALUE_TABLE_ASSERT_SVH
`define ASSOC_LIST_KEY_VALUE_TABLE_ASSERT_SVH

// property checked at every clock edge outside reset
`define ALKV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// property checked at every clock edge, reset included
`define ALKV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/alkv_pkg.sv
package alkv_pkg;

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } op_t;

    // per-cycle commands broadcast along the row of cells
    typedef struct packed {
        logic capture;
        logic write_new;
        logic update;
        logic shift;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/alkv_cell.sv
module alkv_cell #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int CW          = 5,
    parameter int IDX         = 0
) (
    input  logic                   clk,
    input  alkv_pkg::cell_ctrl_t   ctrl,
    input  logic [CW-1:0]          count,
    input  logic [KEY_WIDTH-1:0]   key_in,
    input  logic [KEY_WIDTH-1:0]   key_op,
    input  logic [VALUE_WIDTH-1:0] value_op,
    input  logic [KEY_WIDTH-1:0]   next_key,
    input  logic [VALUE_WIDTH-1:0] next_value,
    input  logic                   hit_in,
    input  logic [VALUE_WIDTH-1:0] data_in,
    output logic [KEY_WIDTH-1:0]   key_q,
    output logic [VALUE_WIDTH-1:0] value_q,
    output logic                   hit_out,
    output logic [VALUE_WIDTH-1:0] data_out,
    output logic                   match
);
    import alkv_pkg::*;

    logic [KEY_WIDTH-1:0]   key_reg;
    logic [KEY_WIDTH-1:0]   key_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   match_reg;
    logic                   match_next;
    logic                   valid;

    assign valid = CW'(IDX) < count;

    always_comb
    begin
        match_next = match_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.capture)
        begin
            match_next = valid && (key_in == key_reg);
        end
        if (ctrl.write_new && (count == CW'(IDX)))
        begin
            key_next   = key_op;
            value_next = value_op;
        end
        else if (ctrl.update && match_reg)
        begin
            value_next = value_op;
        end
        // at and above the removed pair, take the upper neighbor's entry
        else if (ctrl.shift && (hit_in || match_reg) && (CW'(IDX + 1) < count))
        begin
            key_next   = next_key;
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key_q    = key_reg;
    assign value_q  = value_reg;
    assign match    = match_reg;
    assign hit_out  = hit_in || match_reg;
    assign data_out = data_in | (match_reg ? value_reg : '0);

endmodule

// File: hw/rtl/assoc_list_key_value_table.sv
// Key/value table of DEPTH pairs held in a row of cells, packed from cell 0 in insertion
// order. An item (op, key_in, value_in) is taken when start is high and busy is low; keys
// are compared in every cell at that edge, busy is high for the next cycle while the row
// is updated, and the result is shown with done high for the cycle after that. The receiver
// cannot stall: a result must be taken in its one cycle. No new item is taken while busy
// is high, during the match/shift pass that each item makes over the row; the hit and read
// data ripple through all cells in that cycle.
// Reset empties the table by clearing the entry count only.
`include "assoc_list_key_value_table_assert.svh"

module assoc_list_key_value_table #(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     op,
    input  logic [KEY_WIDTH-1:0]           key_in,
    input  logic [VALUE_WIDTH-1:0]         value_in,
    output logic                           done,
    output logic                           found,
    output logic [VALUE_WIDTH-1:0]         value_out,
    output logic                           rejected,
    output logic [$clog2(DEPTH+1)-1:0]     entry_count
);
    import alkv_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    op_t                    op_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   found_reg;
    logic [VALUE_WIDTH-1:0] value_out_reg;
    logic                   rejected_reg;
    logic [VALUE_WIDTH-1:0] value_out_next;
    logic                   rejected_next;

    logic                   accept;
    logic                   hit_any;
    logic                   full;
    cell_ctrl_t             ctrl;

    logic [KEY_WIDTH-1:0]   key_row   [DEPTH];
    logic [VALUE_WIDTH-1:0] value_row [DEPTH];
    logic [DEPTH:0]         hit_chain;
    logic [VALUE_WIDTH-1:0] data_chain [DEPTH+1];
    logic [DEPTH-1:0]       match_vec;

    assign accept  = start && !busy_reg;
    assign hit_any = hit_chain[DEPTH];
    assign full    = count_reg == CW'(DEPTH);

    always_comb
    begin
        ctrl           = '0;
        ctrl.capture   = accept;
        count_next     = count_reg;
        value_out_next = data_chain[DEPTH];
        rejected_next  = 1'b0;
        if (busy_reg)
        begin
            unique case (op_reg)
                OP_INSERT:
                begin
                    ctrl.update    = 1'b1;
                    value_out_next = '0;
                    if (!hit_any)
                    begin
                        if (full)
                        begin
                            rejected_next = 1'b1;
                        end
                        else
                        begin
                            ctrl.write_new = 1'b1;
                            count_next     = count_reg + CW'(1);
                        end
                    end
                end
                OP_POP:
                begin
                    if (hit_any)
                    begin
                        ctrl.shift = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    // get, and the unused code, leave the table alone
                end
            endcase
        end
    end

    assign busy_next = accept;

    assign hit_chain[0]  = 1'b0;
    assign data_chain[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0]   nk;
        logic [VALUE_WIDTH-1:0] nv;

        if (i == DEPTH - 1)
        begin : g_top
            assign nk = key_row[i];
            assign nv = value_row[i];
        end
        else
        begin : g_mid
            assign nk = key_row[i+1];
            assign nv = value_row[i+1];
        end

        alkv_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .CW          (CW),
            .IDX         (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .key_in     (key_in),
            .key_op     (key_reg),
            .value_op   (value_reg),
            .next_key   (nk),
            .next_value (nv),
            .hit_in     (hit_chain[i]),
            .data_in    (data_chain[i]),
            .key_q      (key_row[i]),
            .value_q    (value_row[i]),
            .hit_out    (hit_chain[i+1]),
            .data_out   (data_chain[i+1]),
            .match      (match_vec[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= busy_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(op);
            key_reg   <= key_in;
            value_reg <= value_in;
        end
        if (busy_reg)
        begin
            found_reg     <= hit_any;
            value_out_reg <= value_out_next;
            rejected_reg  <= rejected_next;
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign found       = found_reg;
    assign value_out   = value_out_reg;
    assign rejected    = rejected_reg;
    assign entry_count = count_reg;

    `ALKV_ASSERT(a_done_after_busy, done |-> $past(busy_reg), "result without an update cycle")
    `ALKV_ASSERT_ALWAYS(a_count_bound, !rst_n || (count_reg <= CW'(DEPTH)),
                        "entry count above depth")
    `ALKV_ASSERT(a_single_match, busy_reg |-> $onehot0(match_vec), "key stored twice")
    `ALKV_ASSERT(a_reject_full, (done && rejected) |-> (!found && count_reg == CW'(DEPTH)),
                 "reject while table not full")
    `ALKV_ASSERT(a_count_idle, !busy_reg |=> (count_reg == $past(count_reg)),
                 "entry count moved outside an update")

endmodule
